// ===== src/flat_span_texture_mapper_core_defines.svh =====
// Assertion macros shared by the checker of the flat span texture mapper.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef FLAT_SPAN_TEXTURE_MAPPER_CORE_DEFINES_SVH
`define FLAT_SPAN_TEXTURE_MAPPER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSTM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fstm_pkg.sv =====
// Shared types and constants of the flat span texture mapper.
// No dependencies; the controller, datapath, top level and checker import this package.
`timescale 1ns / 1ps

package fstm_pkg;

    localparam int MAX_RUN_DEF   = 64;
    localparam int TEXEL_DEPTH   = 4096;
    localparam int SHADE_DEPTH   = 256;
    localparam int OUT_FIFO_DEPTH = 4;

    localparam logic [1:0] OP_LOAD_TEXEL = 2'd0;
    localparam logic [1:0] OP_LOAD_SHADE = 2'd1;
    localparam logic [1:0] OP_START_SPAN = 2'd2;
    localparam logic [1:0] OP_EMIT_RUN   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tex_we;
        logic shade_we;
        logic span_load;
        logic issue;
        logic last;
    } fstm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic room;
    } fstm_stat_t;

endpackage

// ===== src/fstm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Reads return the old contents when the same address is written.
`timescale 1ns / 1ps

module fstm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/fstm_ctrl.sv =====
// Controller of the flat span texture mapper: decodes input beats and
// sequences the pixels of a run. Depends on fstm_pkg.
`timescale 1ns / 1ps

module fstm_ctrl
    import fstm_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [6:0] run_length,
    input  fstm_stat_t stat,
    output fstm_cmd_t  cmd
);

    localparam int CNT_W = $clog2(MAX_RUN + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] remain_reg;
    logic [CNT_W-1:0] remain_next;
    logic [CNT_W-1:0] len_sat;
    logic             accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        if (run_length > 7'(MAX_RUN))
        begin
            len_sat = CNT_W'(MAX_RUN);
        end
        else
        begin
            len_sat = CNT_W'(run_length);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        remain_next   = remain_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_LOAD_TEXEL: cmd.tex_we    = 1'b1;
                        OP_LOAD_SHADE: cmd.shade_we  = 1'b1;
                        OP_START_SPAN: cmd.span_load = 1'b1;
                        OP_EMIT_RUN:
                        begin
                            // A run of length zero emits nothing.
                            if (len_sat != '0)
                            begin
                                remain_next = len_sat;
                                state_next  = ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                if (stat.room)
                begin
                    cmd.issue   = 1'b1;
                    cmd.last    = (remain_reg == CNT_W'(1));
                    remain_next = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// ===== src/fstm_dp.sv =====
// Datapath of the flat span texture mapper: span position, texel and shade
// stores, a two-stage lookup pipe and the output FIFO. Depends on fstm_pkg, fstm_ram.
`timescale 1ns / 1ps

module fstm_dp
    import fstm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fstm_cmd_t   cmd,
    output fstm_stat_t  stat,
    input  logic [11:0] table_address,
    input  logic [7:0]  table_data,
    input  logic [31:0] start_position,
    input  logic [31:0] step_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pixel,
    output logic        run_end
);

    localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);
    localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

    logic [31:0] pos_reg;
    logic [31:0] step_reg;
    logic [11:0] texel_addr;
    logic [7:0]  texel_data;
    logic [7:0]  shade_data;

    logic        v1_reg;
    logic        last1_reg;
    logic        v2_reg;
    logic        last2_reg;

    logic [8:0]       fifo_mem [OUT_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] in_flight;
    logic             push;
    logic             pop;

    // Row from position bits 15:10, column from the top six bits.
    assign texel_addr = {pos_reg[15:10], pos_reg[31:26]};

    fstm_ram #(
        .WIDTH(8),
        .DEPTH(TEXEL_DEPTH)
    ) u_texel_ram (
        .clk  (clk),
        .we   (cmd.tex_we),
        .waddr(table_address),
        .wdata(table_data),
        .raddr(texel_addr),
        .rdata(texel_data)
    );

    fstm_ram #(
        .WIDTH(8),
        .DEPTH(SHADE_DEPTH)
    ) u_shade_ram (
        .clk  (clk),
        .we   (cmd.shade_we),
        .waddr(table_address[7:0]),
        .wdata(table_data),
        .raddr(texel_data),
        .rdata(shade_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            step_reg  <= '0;
            v1_reg    <= 1'b0;
            last1_reg <= 1'b0;
            v2_reg    <= 1'b0;
            last2_reg <= 1'b0;
        end
        else
        begin
            if (cmd.span_load)
            begin
                pos_reg  <= start_position;
                step_reg <= step_size;
            end
            else if (cmd.issue)
            begin
                pos_reg <= pos_reg + step_reg;
            end
            v1_reg    <= cmd.issue;
            last1_reg <= cmd.last;
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
        end
    end

    // A pixel is issued only if the FIFO can hold it along with every pixel
    // still in the lookup pipe, so the pipe never has to stop.
    assign in_flight = CNT_W'(v1_reg) + CNT_W'(v2_reg) + count_reg;
    assign stat.room = (in_flight < CNT_W'(OUT_FIFO_DEPTH));

    assign push = v2_reg;
    assign pop  = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= {last2_reg, shade_data};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign out_valid = (count_reg != '0);
    assign pixel     = fifo_mem[rd_ptr_reg][7:0];
    assign run_end   = fifo_mem[rd_ptr_reg][8];

endmodule

// ===== src/flat_span_texture_mapper_core.sv =====
// A load or start beat leaves the input free for the next beat; a run beat of N pixels
// holds the input until all N are issued, longer while the FIFO and lookup pipe lack room.
// Within a run, pixels leave at one per clock while the output is not stalled; each
// pixel passes the texel lookup, the shade lookup and the output FIFO in that order.
// Reset clears the controller, the output FIFO, the span position and step.
// The texel and shade stores are not cleared and hold nothing until written.
`timescale 1ns / 1ps

module flat_span_texture_mapper_core
    import fstm_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [11:0] table_address,
    input  logic [7:0]  table_data,
    input  logic [31:0] start_position,
    input  logic [31:0] step_size,
    input  logic [6:0]  run_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pixel,
    output logic        run_end
);

    fstm_cmd_t  cmd;
    fstm_stat_t stat;

    fstm_ctrl #(
        .MAX_RUN(MAX_RUN)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .run_length(run_length),
        .stat      (stat),
        .cmd       (cmd)
    );

    fstm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .table_address (table_address),
        .table_data    (table_data),
        .start_position(start_position),
        .step_size     (step_size),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel         (pixel),
        .run_end       (run_end)
    );

endmodule

// ===== src/fstm_checker.sv =====
// Port-level checker for the flat span texture mapper, bound to the top level.
// Depends on fstm_pkg and flat_span_texture_mapper_core_defines.svh.
`timescale 1ns / 1ps
`include "flat_span_texture_mapper_core_defines.svh"

module fstm_checker
    import fstm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  operation,
    input logic [11:0] table_address,
    input logic [7:0]  table_data,
    input logic [31:0] start_position,
    input logic [31:0] step_size,
    input logic [6:0]  run_length,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  pixel,
    input logic        run_end
);

    logic       in_take;
    logic       is_run;
    logic       is_load;
    logic       out_wait;
    logic [8:0] out_beat;

    assign in_take  = in_valid && !in_stall;
    assign is_run   = (operation == OP_EMIT_RUN) && (run_length != 7'd0);
    // Every code other than a run is a texel load, a shade load or a span start.
    assign is_load  = (operation != OP_EMIT_RUN);
    assign out_wait = out_valid && out_stall;
    assign out_beat = {run_end, pixel};

    // A stalled output beat keeps its payload.
    `FSTM_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_beat), "stalled beat changed")

    // A run with pixels to emit occupies the block on the next cycle.
    `FSTM_ASSERT_NEXT(a_run_busy, in_take && is_run, in_stall, "run beat did not hold the input")

    // Loads and span starts finish in the cycle they are taken.
    `FSTM_ASSERT_NEXT(a_load_free, in_take && is_load, !in_stall, "load beat held the input")

endmodule

bind flat_span_texture_mapper_core fstm_checker u_fstm_checker (.*);
